// ----- design/lspc_pkg.sv -----
package lspc_pkg;

  localparam logic [15:0] MIN_RANGE_RST    = 16'd150;
  localparam logic [15:0] MAX_RANGE_RST    = 16'd16000;
  localparam logic [31:0] START_ANGLE_RST  = 32'd0;
  localparam logic [31:0] ANGLE_STEP_RST   = 32'd0;
  localparam logic [15:0] FRAME_TARGET_RST = 16'd600;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [16:0] XY_LIMIT     = 17'd65535;
  localparam int unsigned QUEUE_DEPTH  = 4;

  typedef enum logic [2:0] {
    CFG_MIN_RANGE    = 3'd0,
    CFG_MAX_RANGE    = 3'd1,
    CFG_START_ANGLE  = 3'd2,
    CFG_ANGLE_STEP   = 3'd3,
    CFG_FRAME_TARGET = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] min_range_mm;
    logic [15:0] max_range_mm;
    logic [31:0] start_angle;
    logic [31:0] angle_step;
    logic [15:0] frame_target;
  } cfg_t;

  // Per-beat classification handed from the front end to the math pipeline.
  typedef struct packed {
    logic keep;
    logic frame_end;
    logic counted;
    logic done;
  } flags_t;

  // Sine of a binary angle in Q1.15, built from a quarter-wave polynomial in
  // Q2.30. Only evaluated at elaboration to fill the sine ROM.
  function automatic logic signed [16:0] sine_q15(input logic [31:0] b);
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    a = {34'd0, b[29:0]};
    if (b[30]) begin
      a = 64'd1073741824 - a;
    end
    x  = (a * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd110);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd72);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd42);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd20);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    v  = (s + 64'd16384) >> 15;
    return b[31] ? -$signed(v[16:0]) : $signed(v[16:0]);
  endfunction

endpackage

// ----- design/lspc_queue.sv -----
module lspc_queue import lspc_pkg::*; #(
  parameter int unsigned WIDTH = 52
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/lspc_front.sv -----
module lspc_front import lspc_pkg::*; #(
  parameter int unsigned RANGE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  accept_i,
  input  logic [RANGE_BITS-1:0] range_i,
  input  logic                  bad_i,
  input  logic                  first_i,
  input  logic                  last_i,
  output logic [31:0]           angle_o,
  output flags_t                flags_o
);

  localparam int unsigned CMP_W = (RANGE_BITS > 16) ? RANGE_BITS : 16;

  logic [31:0] beam_angle_q, beam_angle_d;
  logic        has_point_q, has_point_d;
  logic [15:0] frames_q, frames_d;
  logic        collecting_q, collecting_d;

  logic [CMP_W-1:0] range_ext;
  logic             in_window;
  logic             seen_point;
  logic [15:0]      frames_inc;

  assign range_ext = CMP_W'(range_i);
  assign in_window = (range_ext >= CMP_W'(cfg_i.min_range_mm))
                  && (range_ext <= CMP_W'(cfg_i.max_range_mm));

  always_comb begin
    angle_o      = first_i ? cfg_i.start_angle : beam_angle_q;
    flags_o      = '0;
    flags_o.frame_end = last_i;
    beam_angle_d = beam_angle_q;
    has_point_d  = has_point_q;
    frames_d     = frames_q;
    collecting_d = collecting_q;
    seen_point   = 1'b0;
    frames_inc   = (frames_q != 16'hFFFF) ? frames_q + 16'd1 : frames_q;
    if (collecting_q) begin
      flags_o.keep    = !bad_i && in_window;
      seen_point      = (has_point_q && !first_i) || flags_o.keep;
      flags_o.counted = last_i && seen_point;
      beam_angle_d    = angle_o + cfg_i.angle_step;
      has_point_d     = seen_point && !last_i;
      if (flags_o.counted) begin
        frames_d     = frames_inc;
        collecting_d = !(frames_inc >= cfg_i.frame_target);
      end
    end
    flags_o.done = !collecting_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_angle_q <= '0;
      has_point_q  <= 1'b0;
      frames_q     <= '0;
      collecting_q <= 1'b1;
    end else if (accept_i) begin
      beam_angle_q <= beam_angle_d;
      has_point_q  <= has_point_d;
      frames_q     <= frames_d;
      collecting_q <= collecting_d;
    end
  end

`ifndef SYNTHESIS
  a_collect_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !collecting_q |=> !collecting_q)
    else $error("collection restarted after it ended");

  a_counted_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && flags_o.counted |-> last_i && collecting_q)
    else $error("frame counted outside a collecting frame end");

  a_frames_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept_i && flags_o.counted) |=> $stable(frames_q))
    else $error("frame count moved without a counted frame");
`endif

endmodule

// ----- design/lspc_back.sv -----
module lspc_back import lspc_pkg::*; #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024,
  parameter int unsigned RANGE_BITS         = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [31:0]           in_angle_i,
  input  logic [RANGE_BITS-1:0] in_range_i,
  input  flags_t                in_flags_i,
  output logic                  in_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [16:0]    out_x_o,
  output logic signed [16:0]    out_y_o,
  output flags_t                out_flags_o
);

  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_ENTRIES);
  localparam int unsigned NUM_W  = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned PROD_W = 32 + NUM_W;
  localparam int unsigned PW     = RANGE_BITS + 18;

  // Sine ROM over one turn, Q1.15 entries, filled at elaboration.
  logic signed [16:0] sine_rom [SINE_TABLE_ENTRIES];

  for (genvar k = 0; k < SINE_TABLE_ENTRIES; k++) begin : g_rom
    localparam logic [31:0] ENTRY_ANGLE =
      32'((64'(k) << 32) / SINE_TABLE_ENTRIES);
    assign sine_rom[k] = sine_q15(ENTRY_ANGLE);
  end

  logic en;

  // Stage A: table indexes.
  logic                  a_vld_q;
  logic [IDX_W-1:0]      a_sin_idx_q, a_cos_idx_q;
  logic [RANGE_BITS-1:0] a_range_q;
  flags_t                a_flags_q;
  logic [PROD_W-1:0]     sin_prod, cos_prod;

  // Stage B: table data.
  logic                  b_vld_q;
  logic signed [16:0]    b_sin_q, b_cos_q;
  logic [RANGE_BITS-1:0] b_range_q;
  flags_t                b_flags_q;

  // Stage C: products.
  logic                  c_vld_q;
  logic signed [PW-1:0]  c_px_q, c_py_q;
  flags_t                c_flags_q;
  logic signed [PW-1:0]  range_s;

  // Output register.
  logic                  out_vld_q;
  logic signed [16:0]    out_x_q, out_y_q;
  flags_t                out_flags_q;

  function automatic logic signed [16:0] round_clamp(input logic signed [PW-1:0] p);
    logic [PW-1:0]    mag;
    logic [PW-1:0]    rnd;
    logic [PW-16:0]   q;
    logic [16:0]      lim;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    rnd = mag + PW'(16384);
    q   = rnd[PW-1:15];
    lim = (q > (PW-15)'(XY_LIMIT)) ? XY_LIMIT : q[16:0];
    return p[PW-1] ? -$signed(lim) : $signed(lim);
  endfunction

  assign en       = !out_vld_q || out_ready_i;
  assign in_pop_o = en && in_valid_i;

  assign sin_prod = PROD_W'(in_angle_i) * PROD_W'(SINE_TABLE_ENTRIES);
  assign cos_prod = PROD_W'(in_angle_i + QUARTER_TURN) * PROD_W'(SINE_TABLE_ENTRIES);
  assign range_s  = $signed(PW'(b_range_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q   <= in_valid_i;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      out_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_sin_idx_q <= sin_prod[32 +: IDX_W];
      a_cos_idx_q <= cos_prod[32 +: IDX_W];
      a_range_q   <= in_range_i;
      a_flags_q   <= in_flags_i;

      b_sin_q     <= sine_rom[a_sin_idx_q];
      b_cos_q     <= sine_rom[a_cos_idx_q];
      b_range_q   <= a_range_q;
      b_flags_q   <= a_flags_q;

      c_px_q      <= range_s * PW'(b_cos_q);
      c_py_q      <= range_s * PW'(b_sin_q);
      c_flags_q   <= b_flags_q;

      out_x_q     <= c_flags_q.keep ? round_clamp(c_px_q) : '0;
      out_y_q     <= c_flags_q.keep ? round_clamp(c_py_q) : '0;
      out_flags_q <= c_flags_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_flags_o = out_flags_q;

`ifndef SYNTHESIS
  a_zero_when_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_flags_q.keep |-> out_x_q == '0 && out_y_q == '0)
    else $error("dropped sample carries coordinates");

  a_counted_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_flags_q.counted |-> out_flags_q.frame_end)
    else $error("counted flag without frame end");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(c_vld_q) && $stable(b_vld_q) && $stable(a_vld_q))
    else $error("pipeline advanced while output stalled");
`endif

endmodule

// ----- design/laser_scan_point_converter.sv -----
// Laser scan point converter: turns a stream of planar scan range samples
// into Cartesian points in millimetres.
// Input beats carry one range sample each: tdata holds the range, tuser flags
// an invalid reading and the first sample of a scan, tlast marks the last one.
// Every input beat yields exactly one output beat, in order. Output tdata holds
// x and y; tuser says whether a point was kept, whether the scan was counted
// at its end, and whether collection has finished; tlast echoes the scan end.
// The front end tracks the beam angle, range window and frame count in the
// accept cycle, so one beat per cycle is sustained while the receiver takes
// results. A four-entry queue feeds a math pipeline (index multiply, sine
// ROM read, range multiply, rounding), registered stage by stage in order.
// The sine ROM read and the 16 by 17 bit multiplies set the pipeline depth.
// When the receiver stalls, the pipeline freezes and the queue absorbs up to
// four beats before s_axis_tready falls; when it pops a beat, tready returns.
// Reset clears the angle, the frame count and the pipeline, restores the
// register defaults and re-enables collection. The user must write registers
// through the plain write port only while no beat is in flight (not enforced).
module laser_scan_point_converter import lspc_pkg::*; #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024,
  parameter int unsigned RANGE_BITS         = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_index_i,
  input  logic [31:0]                         cfg_wdata_i,

  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // bits [RANGE_BITS-1:0]: range_mm, zero padded to whole bytes
  input  logic [((RANGE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // bit 0: range_bad, bit 1: scan_first
  input  logic [1:0]                          s_axis_tuser,
  input  logic                                s_axis_tlast,

  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // bits [16:0]: x_mm, bits [33:17]: y_mm, bits [39:34]: zero
  output logic [39:0]                         m_axis_tdata,
  // bit 0: point_valid, bit 1: frame_counted, bit 2: collection_done
  output logic [2:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int unsigned QW = RANGE_BITS + 32 + $bits(flags_t);

  cfg_t cfg_q;

  // Register file. Writes to indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_range_mm <= MIN_RANGE_RST;
      cfg_q.max_range_mm <= MAX_RANGE_RST;
      cfg_q.start_angle  <= START_ANGLE_RST;
      cfg_q.angle_step   <= ANGLE_STEP_RST;
      cfg_q.frame_target <= FRAME_TARGET_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_RANGE:    cfg_q.min_range_mm <= cfg_wdata_i[15:0];
        CFG_MAX_RANGE:    cfg_q.max_range_mm <= cfg_wdata_i[15:0];
        CFG_START_ANGLE:  cfg_q.start_angle  <= cfg_wdata_i;
        CFG_ANGLE_STEP:   cfg_q.angle_step   <= cfg_wdata_i;
        CFG_FRAME_TARGET: cfg_q.frame_target <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic                  q_full;
  logic                  accept;
  logic [31:0]           f_angle;
  flags_t                f_flags;
  logic                  q_valid;
  logic                  q_pop;
  logic [QW-1:0]         q_wdata, q_rdata;
  logic signed [16:0]    x_mm, y_mm;
  flags_t                o_flags;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && !q_full;

  lspc_front #(
    .RANGE_BITS (RANGE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .range_i  (s_axis_tdata[RANGE_BITS-1:0]),
    .bad_i    (s_axis_tuser[0]),
    .first_i  (s_axis_tuser[1]),
    .last_i   (s_axis_tlast),
    .angle_o  (f_angle),
    .flags_o  (f_flags)
  );

  assign q_wdata = {s_axis_tdata[RANGE_BITS-1:0], f_angle, f_flags};

  lspc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  lspc_back #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .RANGE_BITS         (RANGE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_angle_i  (q_rdata[$bits(flags_t) +: 32]),
    .in_range_i  (q_rdata[QW-1 -: RANGE_BITS]),
    .in_flags_i  (q_rdata[$bits(flags_t)-1:0]),
    .in_pop_o    (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (x_mm),
    .out_y_o     (y_mm),
    .out_flags_o (o_flags)
  );

  assign m_axis_tdata = {6'd0, y_mm, x_mm};
  assign m_axis_tuser = {o_flags.done, o_flags.counted, o_flags.keep};
  assign m_axis_tlast = o_flags.frame_end;

endmodule
